>>> rtl/eight_bit_cpu_alu_with_flags_defines.svh
// assertion macros for the alu block
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef SYNTH

// property checked only while out of reset
`define ALU8F_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("alu8f assertion failed");

// property checked at every edge, reset included
`define ALU8F_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("alu8f assertion failed");

`else

`define ALU8F_ASSERT(lbl, clk, rst_n, prop)
`define ALU8F_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/alu8f_pkg.sv
package alu8f_pkg;

  localparam logic [4:0] CMD_ADD  = 5'd0;
  localparam logic [4:0] CMD_ADC  = 5'd1;
  localparam logic [4:0] CMD_SUB  = 5'd2;
  localparam logic [4:0] CMD_SBC  = 5'd3;
  localparam logic [4:0] CMD_AND  = 5'd4;
  localparam logic [4:0] CMD_XOR  = 5'd5;
  localparam logic [4:0] CMD_OR   = 5'd6;
  localparam logic [4:0] CMD_CP   = 5'd7;
  localparam logic [4:0] CMD_INC  = 5'd8;
  localparam logic [4:0] CMD_DEC  = 5'd9;
  localparam logic [4:0] CMD_DAA  = 5'd10;
  localparam logic [4:0] CMD_SCF  = 5'd11;
  localparam logic [4:0] CMD_CPL  = 5'd12;
  localparam logic [4:0] CMD_CCF  = 5'd13;
  localparam logic [4:0] CMD_RLCA = 5'd14;
  localparam logic [4:0] CMD_RLA  = 5'd15;
  localparam logic [4:0] CMD_RRCA = 5'd16;
  localparam logic [4:0] CMD_RRA  = 5'd17;
  localparam logic [4:0] CMD_RLC  = 5'd18;
  localparam logic [4:0] CMD_RRC  = 5'd19;
  localparam logic [4:0] CMD_RL   = 5'd20;
  localparam logic [4:0] CMD_RR   = 5'd21;
  localparam logic [4:0] CMD_SLA  = 5'd22;
  localparam logic [4:0] CMD_SRA  = 5'd23;
  localparam logic [4:0] CMD_SWAP = 5'd24;
  localparam logic [4:0] CMD_SRL  = 5'd25;
  localparam logic [4:0] CMD_BIT  = 5'd26;
  localparam logic [4:0] CMD_RES  = 5'd27;
  localparam logic [4:0] CMD_SET  = 5'd28;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0] DAA_LO_LIM = 4'h9;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [4:0] cmd;
    logic [7:0] accumulator;
    logic [7:0] operand_byte;
    logic [2:0] bit_index;
    logic [3:0] flags_in;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_write;
    logic [3:0] flags_out;
  } alu_out_t;

endpackage

>>> rtl/alu8f_core.sv
module alu8f_core
  import alu8f_pkg::*;
(
  input  alu_in_t  op_i,
  output alu_out_t res_o
);

  logic [7:0] a;
  logic [7:0] b;
  logic [3:0] f;
  logic       cin;
  logic       cuse;
  logic [8:0] sum9;
  logic [4:0] hsum5;
  logic [8:0] dif9;
  logic [4:0] hdif5;
  logic [7:0] daa1;
  logic [7:0] daa2;
  logic       daa_c;
  logic [7:0] bmask;
  logic [7:0] r;
  logic       wr;
  logic [3:0] nf;

  assign a   = op_i.accumulator;
  assign b   = op_i.operand_byte;
  assign f   = op_i.flags_in;
  assign cin = f[FLAG_C];
  assign cuse = ((op_i.cmd == CMD_ADC) || (op_i.cmd == CMD_SBC)) ? cin : 1'b0;

  assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cuse};
  assign hsum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
  assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cuse};
  assign hdif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};

  // decimal adjust
  always_comb begin
    if (f[FLAG_N]) begin
      daa_c = cin;
      daa1  = cin ? (a - DAA_HI_ADJ) : a;
      daa2  = f[FLAG_H] ? (daa1 - DAA_LO_ADJ) : daa1;
    end else begin
      daa_c = cin || (a > DAA_HI_LIM);
      daa1  = daa_c ? (a + DAA_HI_ADJ) : a;
      daa2  = (f[FLAG_H] || (daa1[3:0] > DAA_LO_LIM)) ? (daa1 + DAA_LO_ADJ) : daa1;
    end
  end

  assign bmask = 8'd1 << op_i.bit_index;

  always_comb begin
    r  = a;
    wr = 1'b1;
    nf = f;
    case (op_i.cmd)
      CMD_ADD, CMD_ADC: begin
        r  = sum9[7:0];
        nf = {(sum9[7:0] == 8'd0), 1'b0, hsum5[4], sum9[8]};
      end
      CMD_SUB, CMD_SBC: begin
        r  = dif9[7:0];
        nf = {(dif9[7:0] == 8'd0), 1'b1, hdif5[4], dif9[8]};
      end
      CMD_CP: begin
        wr = 1'b0;
        nf = {(dif9[7:0] == 8'd0), 1'b1, hdif5[4], dif9[8]};
      end
      CMD_AND: begin
        r  = a & b;
        nf = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      CMD_XOR: begin
        r  = a ^ b;
        nf = {((a ^ b) == 8'd0), 3'b000};
      end
      CMD_OR: begin
        r  = a | b;
        nf = {((a | b) == 8'd0), 3'b000};
      end
      CMD_INC: begin
        r  = b + 8'd1;
        nf = {(b == 8'hFF), 1'b0, (b[3:0] == 4'hF), cin};
      end
      CMD_DEC: begin
        r  = b - 8'd1;
        nf = {(b == 8'h01), 1'b1, (b[3:0] == 4'h0), cin};
      end
      CMD_DAA: begin
        r  = daa2;
        nf = {(daa2 == 8'd0), f[FLAG_N], 1'b0, daa_c};
      end
      CMD_SCF: begin
        wr = 1'b0;
        nf = {f[FLAG_Z], 3'b001};
      end
      CMD_CPL: begin
        r  = ~a;
        nf = {f[FLAG_Z], 2'b11, cin};
      end
      CMD_CCF: begin
        wr = 1'b0;
        nf = {f[FLAG_Z], 2'b00, ~cin};
      end
      CMD_RLCA: begin
        r  = {a[6:0], a[7]};
        nf = {3'b000, a[7]};
      end
      CMD_RLA: begin
        r  = {a[6:0], cin};
        nf = {3'b000, a[7]};
      end
      CMD_RRCA: begin
        r  = {a[0], a[7:1]};
        nf = {3'b000, a[0]};
      end
      CMD_RRA: begin
        r  = {cin, a[7:1]};
        nf = {3'b000, a[0]};
      end
      CMD_RLC: begin
        r  = {b[6:0], b[7]};
        nf = {(b == 8'd0), 2'b00, b[7]};
      end
      CMD_RRC: begin
        r  = {b[0], b[7:1]};
        nf = {(b == 8'd0), 2'b00, b[0]};
      end
      CMD_RL: begin
        r  = {b[6:0], cin};
        nf = {({b[6:0], cin} == 8'd0), 2'b00, b[7]};
      end
      CMD_RR: begin
        r  = {cin, b[7:1]};
        nf = {({cin, b[7:1]} == 8'd0), 2'b00, b[0]};
      end
      CMD_SLA: begin
        r  = {b[6:0], 1'b0};
        nf = {(b[6:0] == 7'd0), 2'b00, b[7]};
      end
      CMD_SRA: begin
        r  = {b[7], b[7:1]};
        nf = {(b[7:1] == 7'd0), 2'b00, b[0]};
      end
      CMD_SWAP: begin
        r  = {b[3:0], b[7:4]};
        nf = {(b == 8'd0), 3'b000};
      end
      CMD_SRL: begin
        r  = {1'b0, b[7:1]};
        nf = {(b[7:1] == 7'd0), 2'b00, b[0]};
      end
      CMD_BIT: begin
        r  = b;
        wr = 1'b0;
        nf = {((b & bmask) == 8'd0), 1'b0, 1'b1, cin};
      end
      CMD_RES: begin
        r = b & ~bmask;
      end
      CMD_SET: begin
        r = b | bmask;
      end
      default: begin
        r  = a;
        wr = 1'b0;
        nf = f;
      end
    endcase
  end

  assign res_o = '{result_byte: r, result_write: wr, flags_out: nf};

endmodule

>>> rtl/eight_bit_cpu_alu_with_flags.sv
// channel  dir  tdata (low bit up)                                tuser         tlast
// in_      in   accumulator 8, operand_byte 8, bit_index 3,       cmd 5         -
//               flags_in 4, zero pad 1
// out_     out  result_byte 8, flags_out 4, zero pad 4            result_write  -
//
// one word per cycle sustained while out_ is not stalled; a word taken on in_ reaches out_
// through the input register, then the result register around a single combinational alu pass
// rst_n is synchronous, active low, and empties both stages
// a stalled out_ holds its word; in_tready drops only when both stages are full
`include "eight_bit_cpu_alu_with_flags_defines.svh"

module eight_bit_cpu_alu_with_flags
  import alu8f_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // accumulator, operand_byte, bit_index, flags_in
  input  logic [4:0]            in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_byte, flags_out
  output logic                  out_tuser   // result_write
);

  logic     s1_v_r;
  logic     s1_v_nxt;
  alu_in_t  s1_r;
  logic     s2_v_r;
  logic     s2_v_nxt;
  alu_out_t s2_r;
  alu_out_t core_res;
  logic     s1_ready;
  logic     s2_ready;
  logic     s1_load;
  logic     s2_load;

  assign s2_ready = !s2_v_r || out_tready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;
  assign s1_load = in_tvalid && s1_ready;
  assign s2_load = s1_v_r && s2_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_ready) begin
      s1_v_nxt = in_tvalid;
    end
    s2_v_nxt = s2_v_r;
    if (s2_ready) begin
      s2_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_r <= '{cmd:          in_tuser,
                accumulator:  in_tdata[7:0],
                operand_byte: in_tdata[15:8],
                bit_index:    in_tdata[18:16],
                flags_in:     in_tdata[22:19]};
    end
    if (s2_load) begin
      s2_r <= core_res;
    end
  end

  alu8f_core u_core (
    .op_i  (s1_r),
    .res_o (core_res)
  );

  assign out_tvalid = s2_v_r;
  assign out_tdata  = {4'd0, s2_r.flags_out, s2_r.result_byte};
  assign out_tuser  = s2_r.result_write;

  `ALU8F_ASSERT_ALWAYS(a_rst_empties, clk, !rst_n |=> (!out_tvalid && !s1_v_r))
  `ALU8F_ASSERT(a_full_blocks_input, clk, rst_n, (s1_v_r && s2_v_r && !out_tready) |-> !in_tready)
  `ALU8F_ASSERT(a_stage_advance, clk, rst_n, (s1_v_r && s2_ready) |=> s2_v_r)
  `ALU8F_ASSERT(a_out_from_stage1, clk, rst_n, $rose(s2_v_r) |-> $past(s1_v_r))

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import alu8f_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MIX_WORDS = 1210;
  localparam int BCD_CHAINS = 220;
  // codes past the last defined operation do nothing
  localparam logic [4:0] CMD_NONE_FIRST = CMD_SET + 5'd1;
  localparam logic [4:0] CMD_NONE_LAST = 5'd31;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [4:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  alu_out_t results_due[$];
  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int cycles = 0;
  int rx_stall = 0;
  bit quiet = 1'b0;

  eight_bit_cpu_alu_with_flags dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic alu_in_t make_word(logic [4:0] cmd, logic [7:0] a, logic [7:0] b,
                                        logic [2:0] idx, logic [3:0] f);
    alu_in_t w;
    w.cmd = cmd;
    w.accumulator = a;
    w.operand_byte = b;
    w.bit_index = idx;
    w.flags_in = f;
    return w;
  endfunction

  function automatic alu_out_t predict_alu(alu_in_t w);
    alu_out_t r;
    logic [8:0] sum;
    logic [4:0] half;
    logic [7:0] a, b, v;
    logic cy, c, cb;
    a = w.accumulator;
    b = w.operand_byte;
    cy = w.flags_in[FLAG_C];
    v = a;
    c = 1'b0;
    cb = 1'b0;
    r.result_byte = a;
    r.result_write = 1'b1;
    r.flags_out = w.flags_in;
    case (w.cmd)
      CMD_ADD, CMD_ADC: begin
        c = (w.cmd == CMD_ADC) ? cy : 1'b0;
        sum = {1'b0, a} + {1'b0, b} + {8'd0, c};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
        r.result_byte = sum[7:0];
        r.flags_out = {sum[7:0] == 8'd0, 1'b0, half[4], sum[8]};
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        c = (w.cmd == CMD_SBC) ? cy : 1'b0;
        sum = {1'b0, a} - {1'b0, b} - {8'd0, c};
        half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c};
        r.flags_out = {sum[7:0] == 8'd0, 1'b1, half[4], sum[8]};
        if (w.cmd == CMD_CP) begin
          r.result_write = 1'b0;
        end else begin
          r.result_byte = sum[7:0];
        end
      end
      CMD_AND: begin
        v = a & b;
        r.result_byte = v;
        r.flags_out = {v == 8'd0, 3'b010};
      end
      CMD_XOR: begin
        v = a ^ b;
        r.result_byte = v;
        r.flags_out = {v == 8'd0, 3'b000};
      end
      CMD_OR: begin
        v = a | b;
        r.result_byte = v;
        r.flags_out = {v == 8'd0, 3'b000};
      end
      CMD_INC: begin
        v = b + 8'd1;
        r.result_byte = v;
        r.flags_out = {v == 8'd0, 1'b0, b[3:0] == 4'hf, cy};
      end
      CMD_DEC: begin
        v = b - 8'd1;
        r.result_byte = v;
        r.flags_out = {v == 8'd0, 1'b1, b[3:0] == 4'h0, cy};
      end
      CMD_DAA: begin
        c = cy;
        if (w.flags_in[FLAG_N]) begin
          if (c) v = v - DAA_HI_ADJ;
          if (w.flags_in[FLAG_H]) v = v - DAA_LO_ADJ;
        end else begin
          if (c || v > DAA_HI_LIM) begin
            v = v + DAA_HI_ADJ;
            c = 1'b1;
          end
          if (w.flags_in[FLAG_H] || v[3:0] > DAA_LO_LIM) v = v + DAA_LO_ADJ;
        end
        r.result_byte = v;
        r.flags_out = {v == 8'd0, w.flags_in[FLAG_N], 1'b0, c};
      end
      CMD_SCF: begin
        r.result_write = 1'b0;
        r.flags_out = {w.flags_in[FLAG_Z], 3'b001};
      end
      CMD_CPL: begin
        r.result_byte = ~a;
        r.flags_out = {w.flags_in[FLAG_Z], 2'b11, cy};
      end
      CMD_CCF: begin
        r.result_write = 1'b0;
        r.flags_out = {w.flags_in[FLAG_Z], 2'b00, ~cy};
      end
      CMD_RLCA: begin
        r.result_byte = {a[6:0], a[7]};
        r.flags_out = {3'b000, a[7]};
      end
      CMD_RLA: begin
        r.result_byte = {a[6:0], cy};
        r.flags_out = {3'b000, a[7]};
      end
      CMD_RRCA: begin
        r.result_byte = {a[0], a[7:1]};
        r.flags_out = {3'b000, a[0]};
      end
      CMD_RRA: begin
        r.result_byte = {cy, a[7:1]};
        r.flags_out = {3'b000, a[0]};
      end
      CMD_RLC: begin
        v = {b[6:0], b[7]};
        c = b[7];
        cb = 1'b1;
      end
      CMD_RRC: begin
        v = {b[0], b[7:1]};
        c = b[0];
        cb = 1'b1;
      end
      CMD_RL: begin
        v = {b[6:0], cy};
        c = b[7];
        cb = 1'b1;
      end
      CMD_RR: begin
        v = {cy, b[7:1]};
        c = b[0];
        cb = 1'b1;
      end
      CMD_SLA: begin
        v = {b[6:0], 1'b0};
        c = b[7];
        cb = 1'b1;
      end
      CMD_SRA: begin
        v = {b[7], b[7:1]};
        c = b[0];
        cb = 1'b1;
      end
      CMD_SWAP: begin
        v = {b[3:0], b[7:4]};
        c = 1'b0;
        cb = 1'b1;
      end
      CMD_SRL: begin
        v = {1'b0, b[7:1]};
        c = b[0];
        cb = 1'b1;
      end
      CMD_BIT: begin
        r.result_byte = b;
        r.result_write = 1'b0;
        r.flags_out = {~b[w.bit_index], 2'b01, cy};
      end
      CMD_RES: begin
        v = b;
        v[w.bit_index] = 1'b0;
        r.result_byte = v;
      end
      CMD_SET: begin
        v = b;
        v[w.bit_index] = 1'b1;
        r.result_byte = v;
      end
      default: begin
        r.result_write = 1'b0;
      end
    endcase
    if (cb) begin
      r.result_byte = v;
      r.flags_out = {v == 8'd0, 2'b00, c};
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at word %0d: %s got %0h expected %0h", words_seen, field, got, want);
    errors++;
  endtask

  // valid stays high from one word to the next when there is no gap
  task automatic issue_op(alu_in_t w);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, w.flags_in, w.bit_index, w.operand_byte, w.accumulator};
    in_tuser <= w.cmd;
    do @(posedge clk); while (!in_tready);
    results_due.push_back(predict_alu(w));
    words_sent++;
  endtask

  always @(posedge clk) begin
    alu_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (results_due.size() == 0) begin
        $display("unexpected word %0d: tdata %0h tuser %0b", words_seen, out_tdata, out_tuser);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (out_tdata[7:0] !== want.result_byte)
          report_mismatch("result_byte", int'(out_tdata[7:0]), int'(want.result_byte));
        if (out_tuser !== want.result_write)
          report_mismatch("result_write", int'(out_tuser), int'(want.result_write));
        if (out_tdata[11:8] !== want.flags_out)
          report_mismatch("flags_out", int'(out_tdata[11:8]), int'(want.flags_out));
      end
      rx_stall = draw_wait();
    end
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, results_due.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    issue_op(make_word(CMD_ADD, 8'hff, 8'h01, 3'd0, 4'b0000));
    issue_op(make_word(CMD_ADC, 8'h0f, 8'h00, 3'd0, 4'b0001));
    issue_op(make_word(CMD_SUB, 8'h00, 8'h01, 3'd0, 4'b0000));
    issue_op(make_word(CMD_SBC, 8'h10, 8'h0f, 3'd0, 4'b0001));
    issue_op(make_word(CMD_AND, 8'hff, 8'h00, 3'd0, 4'b1111));
    issue_op(make_word(CMD_XOR, 8'hff, 8'hff, 3'd0, 4'b0111));
    issue_op(make_word(CMD_OR, 8'hff, 8'h00, 3'd0, 4'b1111));
    issue_op(make_word(CMD_CP, 8'h42, 8'h42, 3'd0, 4'b0000));
    issue_op(make_word(CMD_INC, 8'h00, 8'hff, 3'd0, 4'b0001));
    issue_op(make_word(CMD_DEC, 8'hff, 8'h00, 3'd0, 4'b0000));
    // adjust that wraps to zero, then the subtract side with both corrections
    issue_op(make_word(CMD_DAA, 8'h9a, 8'h00, 3'd0, 4'b0000));
    issue_op(make_word(CMD_DAA, 8'h00, 8'h00, 3'd0, 4'b0111));
    issue_op(make_word(CMD_SCF, 8'h55, 8'haa, 3'd0, 4'b1110));
    issue_op(make_word(CMD_CPL, 8'hff, 8'h00, 3'd0, 4'b1001));
    issue_op(make_word(CMD_CCF, 8'h00, 8'hff, 3'd0, 4'b0111));
    issue_op(make_word(CMD_RLCA, 8'h80, 8'h00, 3'd0, 4'b1000));
    issue_op(make_word(CMD_RRA, 8'h01, 8'h00, 3'd0, 4'b1110));
    issue_op(make_word(CMD_RL, 8'h00, 8'h80, 3'd0, 4'b0000));
    issue_op(make_word(CMD_SRA, 8'h00, 8'h81, 3'd0, 4'b0000));
    issue_op(make_word(CMD_SWAP, 8'h00, 8'hf0, 3'd0, 4'b0111));
    issue_op(make_word(CMD_SRL, 8'h00, 8'h01, 3'd0, 4'b0000));
    issue_op(make_word(CMD_BIT, 8'h00, 8'h7f, 3'd7, 4'b0101));
    issue_op(make_word(CMD_RES, 8'h00, 8'hff, 3'd0, 4'b1010));
    issue_op(make_word(CMD_SET, 8'hff, 8'h00, 3'd7, 4'b0101));
    issue_op(make_word(CMD_NONE_FIRST, 8'h3c, 8'hc3, 3'd5, 4'b1010));
    issue_op(make_word(CMD_NONE_LAST, 8'hff, 8'hff, 3'd7, 4'b1111));
  endtask

  task automatic test_random_mix();
    logic [4:0] cmd;
    int i;
    for (i = 0; i < MIX_WORDS; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        cmd = 5'($urandom_range(CMD_NONE_FIRST, CMD_NONE_LAST));
      else
        cmd = 5'($urandom_range(CMD_ADD, CMD_SET));
      issue_op(make_word(cmd, 8'($urandom), 8'($urandom), 3'($urandom), 4'($urandom)));
    end
    quiet = 1'b0;
  endtask

  // bcd add or subtract followed by the decimal adjust it feeds
  task automatic test_bcd_chains();
    alu_in_t op;
    alu_out_t mid;
    logic [4:0] cmd;
    logic [7:0] x, y;
    int i;
    for (i = 0; i < BCD_CHAINS; i++) begin
      x = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      y = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      case ($urandom_range(0, 3))
        0: cmd = CMD_ADD;
        1: cmd = CMD_ADC;
        2: cmd = CMD_SUB;
        default: cmd = CMD_SBC;
      endcase
      op = make_word(cmd, x, y, 3'($urandom), 4'($urandom));
      mid = predict_alu(op);
      issue_op(op);
      // a few broken chains with a disturbed flag and byte
      if ($urandom_range(0, 6) == 0) begin
        mid.flags_out[2'($urandom_range(0, 3))] ^= 1'b1;
        mid.result_byte ^= 8'($urandom);
      end
      issue_op(make_word(CMD_DAA, mid.result_byte, 8'($urandom), 3'($urandom),
                         mid.flags_out));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_bcd_chains();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d words, checked %0d results", words_sent, words_seen);
    $display("covered every operation code, undefined codes and %0d bcd adjust chains",
             BCD_CHAINS);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/alu8f_pkg.sv
rtl/alu8f_core.sv
rtl/eight_bit_cpu_alu_with_flags.sv
dv/testbench.sv
